### src/sui_pkg.sv
// Package for the sorted unique insert table.
// Holds widths, the default depth, the sequencer states and the compare result type.
package sui_pkg;

  localparam int SUI_DEPTH = 64;  // default table depth
  localparam int VAL_W     = 32;  // width of one stored value
  localparam int FLD_W     = 7;   // width of the position and entry_count result fields

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_SHIFT,
    ST_DONE
  } sui_state_t;

  typedef struct packed {
    logic lt;  // table entry is less than the probe value (signed order)
    logic eq;  // table entry equals the probe value
  } cmp_res_t;

endpackage

### src/sorted_unique_insert_table.sv
// Top level of the sorted unique insert table.
// Depends on sui_pkg, sui_ram (entry storage) and sui_cmp (compare unit).
//
// The table holds up to DEPTH distinct signed 32-bit values in ascending order.
// Each in_ beat carries one value and yields exactly one out_ beat. The block
// finds the lower-bound position of the value: the first entry that is not less
// than it. An equal entry leaves the table unchanged; a new value shifts the
// higher entries up one place and fills the gap; on a full table a new value is
// dropped and flagged with out_dropped_full.
//
// One item is in work at a time, and in_stall stays high until it is done. Each
// binary-search probe is a read of the entry RAM in ST_SEARCH, then a compare on
// its registered data in ST_CMP; the search makes at most ceil(log2(count+1))
// probes. A duplicate or a drop then goes to ST_DONE. An insert first moves each
// higher entry up one slot in ST_SHIFT, reading one entry ahead of the write,
// and then writes the value into the gap. The next beat is taken in the cycle
// after the result is loaded.
//
// rst_n is synchronous and active low. It empties the table and the output
// register but leaves the RAM as it is, since only entries below the count are
// read. While out_stall holds a result in the output register, a finished item
// waits in its final state, so the input stays stalled until the register frees.
module sorted_unique_insert_table #(
  parameter int DEPTH = sui_pkg::SUI_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [sui_pkg::VAL_W-1:0] in_value,
  // Result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_inserted,
  output logic                      out_dropped_full,
  output logic [sui_pkg::FLD_W-1:0] out_position,
  output logic [sui_pkg::FLD_W-1:0] out_entry_count
);
  import sui_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Sequencer state and working registers.
  sui_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  mid_r, mid_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              eq_r, eq_nxt;
  logic              ins_r, ins_nxt;
  logic              drop_r, drop_nxt;
  logic              wpend_r, wpend_nxt;
  logic [IDX_W-1:0]  waddr_r, waddr_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic              out_ins_r, out_ins_nxt;
  logic              out_drop_r, out_drop_nxt;
  logic [FLD_W-1:0]  out_pos_r, out_pos_nxt;
  logic [FLD_W-1:0]  out_cnt_r, out_cnt_nxt;

  // RAM port signals.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // Helper values.
  logic [CNT_W-1:0]  mid_calc;
  logic [CNT_W-1:0]  cur_dec;
  logic [CNT_W-1:0]  count_after;
  logic              full;
  cmp_res_t          cmp;

  sui_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The one compare unit; it only matters while the sequencer sits in ST_CMP.
  sui_cmp u_cmp (
    .entry (ram_rdata),
    .probe (val_r),
    .res   (cmp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wpend_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      wpend_r     <= wpend_nxt;
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    cur_r      <= cur_nxt;
    val_r      <= val_nxt;
    eq_r       <= eq_nxt;
    ins_r      <= ins_nxt;
    drop_r     <= drop_nxt;
    waddr_r    <= waddr_nxt;
    out_ins_r  <= out_ins_nxt;
    out_drop_r <= out_drop_nxt;
    out_pos_r  <= out_pos_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign mid_calc    = lo_r + ((hi_r - lo_r) >> 1);
  assign cur_dec     = cur_r - CNT_W'(1);
  assign count_after = count_r + CNT_W'(ins_r);
  assign full        = count_r == CNT_W'(DEPTH);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    cur_nxt       = cur_r;
    val_nxt       = val_r;
    eq_nxt        = eq_r;
    ins_nxt       = ins_r;
    drop_nxt      = drop_r;
    wpend_nxt     = wpend_r;
    waddr_nxt     = waddr_r;
    out_ins_nxt   = out_ins_r;
    out_drop_nxt  = out_drop_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = waddr_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = mid_calc[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          val_nxt   = in_value;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          eq_nxt    = 1'b0;
          state_nxt = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        if (lo_r < hi_r) begin
          // Probe the midpoint; its data comes back next cycle.
          ram_raddr = mid_calc[IDX_W-1:0];
          mid_nxt   = mid_calc;
          state_nxt = ST_CMP;
        end else if (eq_r) begin
          // The last entry that bounded the search from above equals the value.
          ins_nxt   = 1'b0;
          drop_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else if (full) begin
          ins_nxt   = 1'b0;
          drop_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ins_nxt   = 1'b1;
          drop_nxt  = 1'b0;
          cur_nxt   = count_r;
          wpend_nxt = 1'b0;
          state_nxt = ST_SHIFT;
        end
      end

      ST_CMP: begin
        if (cmp.lt) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt = mid_r;
          eq_nxt = cmp.eq;
        end
        state_nxt = ST_SEARCH;
      end

      ST_SHIFT: begin
        // Reads run one entry ahead of writes: entry cur-1 is read now and
        // written to slot cur in the next cycle.
        if (wpend_r) begin
          ram_we    = 1'b1;
          ram_waddr = waddr_r;
          ram_wdata = ram_rdata;
        end
        if (cur_r > lo_r) begin
          ram_raddr = cur_dec[IDX_W-1:0];
          wpend_nxt = 1'b1;
          waddr_nxt = cur_r[IDX_W-1:0];
          cur_nxt   = cur_dec;
        end else begin
          wpend_nxt = 1'b0;
          if (!wpend_r) begin
            ram_we    = 1'b1;
            ram_waddr = lo_r[IDX_W-1:0];
            ram_wdata = val_r;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ins_nxt   = ins_r;
          out_drop_nxt  = drop_r;
          out_pos_nxt   = FLD_W'(lo_r);
          out_cnt_nxt   = FLD_W'(count_after);
          count_nxt     = count_after;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall         = state_r != ST_IDLE;
  assign out_valid        = out_valid_r;
  assign out_inserted     = out_ins_r;
  assign out_dropped_full = out_drop_r;
  assign out_position     = out_pos_r;
  assign out_entry_count  = out_cnt_r;

endmodule

### src/sui_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the width and depth come in as parameters.
module sui_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sui_cmp.sv
// Compare unit: signed less-than and equality of a table entry against the probe.
// Depends on sui_pkg for the value width and the result struct.
module sui_cmp (
  input  logic [sui_pkg::VAL_W-1:0] entry,
  input  logic [sui_pkg::VAL_W-1:0] probe,
  output sui_pkg::cmp_res_t         res
);
  import sui_pkg::*;

  always_comb begin
    res.lt = $signed(entry) < $signed(probe);
    res.eq = entry == probe;
  end

endmodule

### src/sui_chk.sv
// Port-level checker for the sorted unique insert table, and its bind to the top level.
// Depends on sui_pkg for the field widths.
module sui_chk #(
  parameter int DEPTH = sui_pkg::SUI_DEPTH
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_inserted,
  input logic                      out_dropped_full,
  input logic [sui_pkg::FLD_W-1:0] out_position,
  input logic [sui_pkg::FLD_W-1:0] out_entry_count
);
  import sui_pkg::*;

  localparam bit FITS = DEPTH <= 64;

  // A stalled result beat holds its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inserted) &&
      $stable(out_dropped_full) && $stable(out_position) && $stable(out_entry_count))
    else $error("result beat changed while stalled");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inserted && out_dropped_full))
    else $error("inserted and dropped_full both set");

  // A freshly inserted value sits below the new count.
  a_ins_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inserted |-> !FITS || (out_position < out_entry_count))
    else $error("inserted position not below entry count");

  // A drop only happens on a full table.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped_full |->
      !FITS || (out_entry_count == FLD_W'(DEPTH) && out_position <= FLD_W'(DEPTH)))
    else $error("drop reported on a table that is not full");

endmodule

bind sorted_unique_insert_table sui_chk #(
  .DEPTH (DEPTH)
) u_sui_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_inserted     (out_inserted),
  .out_dropped_full (out_dropped_full),
  .out_position     (out_position),
  .out_entry_count  (out_entry_count)
);

### bench/sui_insert_checker.sv
`timescale 1ns / 1ps
// Result checker for the sorted unique insert table bench.
// Keeps its own sorted copy of the table and compares every result beat with it.
// Depends on sui_pkg for the value and field widths.
module sui_insert_checker #(
  parameter int DEPTH = sui_pkg::SUI_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [sui_pkg::VAL_W-1:0] in_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_inserted,
  input  logic                      out_dropped_full,
  input  logic [sui_pkg::FLD_W-1:0] out_position,
  input  logic [sui_pkg::FLD_W-1:0] out_entry_count,
  output int                        mismatch_cnt,
  output int                        outstanding
);
  import sui_pkg::*;

  typedef struct packed {
    logic             inserted;
    logic             dropped_full;
    logic [FLD_W-1:0] position;
    logic [FLD_W-1:0] entry_count;
  } insert_result_t;

  logic signed [VAL_W-1:0] model_vals [DEPTH];
  int                      held = 0;
  int                      fail_total = 0;
  insert_result_t          pending_results [$];

  // Lower-bound search by signed order, then either a no-op on a duplicate,
  // a drop on a full table, or a shift-up insert.
  function automatic insert_result_t predict_insert(input logic signed [VAL_W-1:0] v);
    insert_result_t r;
    int             pos;
    r   = '0;
    pos = 0;
    while (pos < held && model_vals[pos] < v) pos++;
    r.position = pos[FLD_W-1:0];
    if (pos < held && model_vals[pos] == v) begin
      r.inserted = 1'b0;
    end else if (held >= DEPTH) begin
      r.dropped_full = 1'b1;
    end else begin
      for (int i = held; i > pos; i--) model_vals[i] = model_vals[i-1];
      model_vals[pos] = v;
      held++;
      r.inserted = 1'b1;
    end
    r.entry_count = held[FLD_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [FLD_W-1:0] exp_v,
                             input logic [FLD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_total++;
    end
  endtask

  // The result side is handled before the input side, so that a beat arriving
  // with nothing pending is caught even when an item is taken at the same edge.
  always @(posedge clk) begin
    insert_result_t exp_r;
    if (!rst_n) begin
      held = 0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no prediction pending");
          fail_total++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("inserted", FLD_W'(exp_r.inserted), FLD_W'(out_inserted));
          check_field("dropped_full", FLD_W'(exp_r.dropped_full),
                      FLD_W'(out_dropped_full));
          check_field("position", exp_r.position, out_position);
          check_field("entry_count", exp_r.entry_count, out_entry_count);
        end
      end
      if (in_valid && !in_stall) begin
        pending_results = {pending_results, predict_insert(in_value)};
      end
    end
    mismatch_cnt <= fail_total;
    outstanding  <= pending_results.size();
  end

endmodule

### bench/sorted_unique_insert_table_tb.sv
`timescale 1ns / 1ps
// Top of the sorted unique insert table bench: clock, reset, stimulus and verdict.
// Depends on sui_pkg, the sorted_unique_insert_table block and sui_insert_checker.
module sorted_unique_insert_table_tb;
  import sui_pkg::*;

  localparam int DEPTH        = SUI_DEPTH;
  localparam int NUM_ITEMS    = 500;
  // The receiver freezes once, after HOLD_AT input beats; HOLD_CYCLES sets the hold.
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int LIMIT_CYCLES = 400000;

  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  // The opening sequence works on an empty table. It inserts at the front, at
  // the end and in the middle, repeats values already stored (duplicates at
  // the first, a middle and the last slot) and stores the most negative value.
  // The most positive value is held back until the table is full: only then
  // can a dropped value report the position one past the last entry.
  localparam int NUM_DIRECTED = 14;
  localparam logic [VAL_W-1:0] DIRECTED [NUM_DIRECTED] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_03E8, 32'hFFFF_FC18,
    VAL_MIN,       VAL_MIN,       32'hFFFF_FFFF, 32'h0000_0001,
    32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFE,
    32'hFFFF_FFFF, 32'h0000_03E8
  };

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic [VAL_W-1:0] in_value  = '0;
  logic             out_stall = 1'b0;

  logic             in_stall;
  logic             out_valid;
  logic             out_inserted;
  logic             out_dropped_full;
  logic [FLD_W-1:0] out_position;
  logic [FLD_W-1:0] out_entry_count;

  int mismatch_cnt;
  int outstanding;

  // Idle rates in percent per cycle; the stimulus thread moves them per phase.
  int tx_idle_pct = 13;
  int rx_idle_pct = 51;

  // Every distinct value offered so far. Once it holds DEPTH values the table
  // is known to be full, and it feeds duplicates and near neighbors.
  logic [VAL_W-1:0] distinct_vals [$];

  int unsigned cycle_cnt   = 0;
  int          taken_beats = 0;
  int          hold_left   = 0;
  logic        held_off    = 1'b0;

  always #10 clk = ~clk;

  sorted_unique_insert_table #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_inserted     (out_inserted),
    .out_dropped_full (out_dropped_full),
    .out_position     (out_position),
    .out_entry_count  (out_entry_count)
  );

  sui_insert_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_inserted     (out_inserted),
    .out_dropped_full (out_dropped_full),
    .out_position     (out_position),
    .out_entry_count  (out_entry_count),
    .mismatch_cnt     (mismatch_cnt),
    .outstanding      (outstanding)
  );

  // Watchdog. The limit is several times the slowest legal run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver. It stalls at random at the current rate, except for one long
  // hold-off, counted here in cycles, that starts after HOLD_AT input beats.
  // The block holds one item in work and one result in its output register,
  // so the sender, which keeps offering, soon sees in_stall stay high.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) taken_beats <= taken_beats + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held_off && taken_beats == HOLD_AT) begin
      held_off  <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Offers one value, with random idle cycles in front of it, and returns in
  // the time step of the edge that accepts the beat. The payload is held
  // steady while the block stalls.
  task automatic send_beat(input logic [VAL_W-1:0] v);
    logic seen;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    seen = 1'b0;
    foreach (distinct_vals[i]) begin
      if (distinct_vals[i] == v) seen = 1'b1;
    end
    if (!seen) distinct_vals = {distinct_vals, v};
  endtask

  // Most random values are built from what the table already holds: exact
  // repeats reach the duplicate path at any slot, and neighbors one above or
  // below land between stored entries, so inserts fall all over the table.
  // The rest are field extremes, small values around zero and full-range
  // values. Until the table is full the most positive value is avoided.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned      r;
    logic             table_full;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] cand;
    table_full = (distinct_vals.size() >= DEPTH);
    base = (distinct_vals.size() == 0) ? '0 :
           distinct_vals[$urandom_range(distinct_vals.size() - 1)];
    r = $urandom_range(99);
    if (r < 35) begin
      cand = base;
    end else if (r < 55) begin
      cand = $urandom_range(1) ? base + 1 : base - 1;
    end else if (r < 65) begin
      case ($urandom_range(4))
        0: begin
          cand = VAL_MIN;
        end
        1: begin
          cand = VAL_MIN + 1;
        end
        2: begin
          cand = '0;
        end
        3: begin
          cand = '1;
        end
        default: begin
          cand = VAL_MAX;
        end
      endcase
    end else if (r < 80) begin
      cand = $urandom_range(255) - 128;
    end else begin
      cand = $urandom;
    end
    if (!table_full && cand == VAL_MAX) cand = VAL_MAX - 1;
    return cand;
  endfunction

  // Stimulus. The run has three phases of equal length: a fast sender with a
  // busy receiver, then the reverse, then both sides at full rate. The table
  // never shrinks, so it fills early and the later beats exercise duplicate
  // hits and drops on a full table.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int n = 0; n < NUM_ITEMS; n++) begin
      if (n == NUM_ITEMS / 3) begin
        tx_idle_pct = 51;
        rx_idle_pct = 13;
      end else if (n == 2 * NUM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (n < NUM_DIRECTED) begin
        send_beat(DIRECTED[n]);
      end else if (distinct_vals.size() == DEPTH) begin
        // First beat on a full table: a value above every entry is dropped
        // with the position one past the end.
        send_beat(VAL_MAX);
      end else begin
        send_beat(pick_value());
      end
    end
    in_valid <= 1'b0;

    // Let every predicted result arrive, then watch a while longer for any
    // stray beat before giving the verdict.
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
